/* rtl/apq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_pkg
// Shared types and constants for the ascending priority queue.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int Depth  = 8;
  localparam int ValueW = 32;
  localparam int CountW = $clog2(Depth + 1);

  typedef enum logic {
    OpEnqueue = 1'b0,
    OpDequeue = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusOverflow = 2'd1,
    StatusEmpty    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CmdHold,
    CmdEnqueue,
    CmdDequeue,
    CmdFlush
  } cell_cmd_e;

  typedef struct packed {
    opcode_e            opcode;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] removed_value;
    logic [3:0]         occupancy;
  } res_t;

  typedef struct packed {
    cell_cmd_e                op;
    logic signed [ValueW-1:0] value;
  } cell_ctrl_t;

  typedef struct packed {
    logic signed [ValueW-1:0] entry;
    logic                     valid;
    logic                     greater;
  } link_t;

endpackage

/* rtl/apq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_cell
// One slot of the sorted chain: compares, shifts right on insert, left on pop.
// ----------------------------------------------------------------------------
module apq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  apq_pkg::cell_ctrl_t ctrl_i,
  input  apq_pkg::link_t     left_i,
  input  apq_pkg::link_t     right_i,
  output apq_pkg::link_t     link_o
);
  import apq_pkg::*;

  logic signed [ValueW-1:0] entry_q, entry_d;
  logic                     valid_q, valid_d;
  logic                     greater;

  // entry moves right when the new value sorts before it
  assign greater = valid_q && (ctrl_i.value < entry_q);

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      CmdEnqueue: begin
        if (left_i.greater) begin
          entry_d = left_i.entry;
        end else if (greater || !valid_q) begin
          entry_d = ctrl_i.value;
        end
        valid_d = valid_q | left_i.valid;
      end
      CmdDequeue: begin
        entry_d = right_i.entry;
        valid_d = right_i.valid;
      end
      CmdFlush: begin
        valid_d = 1'b0;
      end
      default: begin
        entry_d = entry_q;
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign link_o = '{entry: entry_q, valid: valid_q, greater: greater};

endmodule

/* rtl/ascending_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascending_priority_queue
// Bounded sorted queue built from a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// the result strobes in the cycle after the transaction is accepted
// throughput: one transaction per cycle; the cell chain never stalls
// busy stays low; the receiver cannot stall, each result shows for one cycle
// reset: asynchronous, active low; clears the queue to empty
module ascending_priority_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  apq_pkg::req_t req_i,
  output logic          done_o,
  output apq_pkg::res_t res_o
);
  import apq_pkg::*;

  logic              accept;
  logic              full, empty;
  logic [CountW-1:0] count_q, count_d;
  logic              done_q;
  res_t              res_q, res_d;
  cell_ctrl_t        ctrl;
  link_t             links [Depth];
  link_t             lefts [Depth];
  link_t             rights[Depth];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CountW'(Depth));
  assign empty  = (count_q == '0);

  always_comb begin
    ctrl.op    = CmdHold;
    ctrl.value = signed'(ValueW'($unsigned(req_i.value)));
    count_d    = count_q;
    res_d      = res_q;
    if (accept) begin
      res_d.removed_value = '0;
      res_d.status        = StatusOk;
      case (req_i.opcode)
        OpEnqueue: begin
          if (full) begin
            ctrl.op      = CmdFlush;
            count_d      = '0;
            res_d.status = StatusOverflow;
          end else begin
            ctrl.op = CmdEnqueue;
            count_d = count_q + CountW'(1);
          end
        end
        OpDequeue: begin
          if (empty) begin
            res_d.status = StatusEmpty;
          end else begin
            ctrl.op             = CmdDequeue;
            count_d             = count_q - CountW'(1);
            res_d.removed_value = 32'(links[0].entry);
          end
        end
        default: begin
          ctrl.op = CmdHold;
        end
      endcase
      res_d.occupancy = 4'(count_d);
    end
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lefts[i] = '{entry: '0, valid: 1'b1, greater: 1'b0};
    end else begin : g_mid
      assign lefts[i] = links[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign rights[i] = '{entry: '0, valid: 1'b0, greater: 1'b0};
    end else begin : g_body
      assign rights[i] = links[i+1];
    end

    apq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .left_i (lefts[i]),
      .right_i(rights[i]),
      .link_o (links[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
